/* src/sha1s_pkg.sv */
// Shared types and constants for the SHA-1 stream hash.
// Used by sha1s_round and sha1_stream_hash; no dependencies.
package sha1s_pkg;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned RND_W  = 7;

	// Initial chaining values, H0 in the top slot.
	localparam logic [4:0][31:0] SHA1S_INIT = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_CH  = 32'h5A827999;
	localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
	localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Working variables of the compression rounds.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha1s_vars_t;

endpackage

/* src/sha1s_round.sv */
// One SHA-1 compression round, shared across all 80 rounds of a block.
// Depends on sha1s_pkg for the working-variable struct and round constants.
module sha1s_round
	import sha1s_pkg::*;
(
	input  sha1s_vars_t      cur,
	input  logic [31:0]      w,
	input  logic [RND_W-1:0] rnd,
	output sha1s_vars_t      nxt
);

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] t;

	always_comb begin
		if (rnd < RND_W'(20)) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_CH;
		end else if (rnd < RND_W'(40)) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_PA1;
		end else if (rnd < RND_W'(60)) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K_MAJ;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_PA2;
		end
	end

	assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

	always_comb begin
		nxt.a = t;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

/* src/sha1_stream_hash.sv */
// SHA-1 stream hash: one message byte per append word, digest on finish.
// Appends are taken in IDLE; the byte that fills a block starts the 80 rounds and the update.
// No further byte is taken until that block is compressed, as the single round unit is busy.
// Finish: pad and length bytes, one or two blocks compressed, then 5 output words.
// Reset (arst_n low, asynchronous): chaining words to the initial values, fill, length and
// control cleared; the block buffer is not cleared and is always written before use.
module sha1_stream_hash
	import sha1s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  message_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PAD    = 5'b00010,
		ST_ROUND  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	localparam logic [5:0]       FILL_LAST  = 6'd63;
	localparam logic [5:0]       FILL_PRE_LEN = 6'd55;
	localparam logic [RND_W-1:0] RND_LAST   = RND_W'(ROUNDS - 1);
	localparam logic [2:0]       IDX_LAST   = 3'd4;

	state_t           state_q;
	logic [511:0]     blk_q;
	logic [5:0]       fill_q;
	logic [63:0]      len_q;
	logic [4:0][31:0] h_q;
	sha1s_vars_t      vars_q;
	sha1s_vars_t      vars_nxt;
	logic [RND_W-1:0] rnd_q;
	logic             fin_q;
	logic             first_q;
	logic             len_mode_q;
	logic [2:0]       idx_q;

	logic [31:0] w0, w2, w8, w13, w_x, w_r;
	logic [7:0]  pad_byte;
	logic        in_fire;
	logic        out_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	assign digest_word = h_q[3'd4 - idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == IDX_LAST);

	// Schedule window: oldest word at the top of the buffer.
	assign w0  = blk_q[511:480];
	assign w2  = blk_q[447:416];
	assign w8  = blk_q[255:224];
	assign w13 = blk_q[95:64];
	assign w_x = w13 ^ w8 ^ w2 ^ w0;
	assign w_r = (rnd_q < RND_W'(16)) ? w0 : {w_x[30:0], w_x[31]};

	assign pad_byte = first_q ? PAD_BYTE : (len_mode_q ? len_q[63:56] : 8'h00);

	sha1s_round u_round (
		.cur (vars_q),
		.w   (w_r),
		.rnd (rnd_q),
		.nxt (vars_nxt)
	);

	// Buffer and working variables carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire && !command) begin
			blk_q <= {blk_q[503:0], message_byte};
		end else if (state_q == ST_PAD) begin
			blk_q <= {blk_q[503:0], pad_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_r};
		end
		if (state_q == ST_ROUND) begin
			vars_q <= vars_nxt;
		end else begin
			vars_q <= {h_q[4], h_q[3], h_q[2], h_q[1], h_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			len_q      <= '0;
			h_q        <= SHA1S_INIT;
			rnd_q      <= '0;
			fin_q      <= 1'b0;
			first_q    <= 1'b0;
			len_mode_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (command) begin
							// Hold the bit length for the trailing length bytes.
							len_q   <= {len_q[60:0], 3'b000};
							fin_q   <= 1'b1;
							first_q <= 1'b1;
							state_q <= ST_PAD;
						end else begin
							len_q  <= len_q + 64'd1;
							fill_q <= fill_q + 6'd1;
							if (fill_q == FILL_LAST) begin
								rnd_q   <= '0;
								state_q <= ST_ROUND;
							end
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					fill_q  <= fill_q + 6'd1;
					if (len_mode_q) begin
						len_q <= {len_q[55:0], 8'h00};
					end
					if (fill_q == FILL_LAST) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end else if (fill_q == FILL_PRE_LEN && !len_mode_q) begin
						len_mode_q <= 1'b1;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + RND_W'(1);
					if (rnd_q == RND_LAST) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					h_q[4] <= h_q[4] + vars_q.a;
					h_q[3] <= h_q[3] + vars_q.b;
					h_q[2] <= h_q[2] + vars_q.c;
					h_q[1] <= h_q[1] + vars_q.d;
					h_q[0] <= h_q[0] + vars_q.e;
					if (fin_q && len_mode_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_fire) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == IDX_LAST) begin
							// Drop back to a fresh message.
							h_q        <= SHA1S_INIT;
							fill_q     <= '0;
							len_q      <= '0;
							fin_q      <= 1'b0;
							len_mode_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while digest is being emitted");

	a_fill_empty_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_q == 6'd0 && len_mode_q && fin_q))
		else $error("digest emitted with buffer not drained");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= RND_LAST))
		else $error("round counter out of range");

	a_final_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && fin_q && len_mode_q) |=> (state_q == ST_EMIT && idx_q == 3'd0))
		else $error("final block not followed by digest output");

endmodule

/* dv/tb_sha1_stream_hash.sv */
// Testbench for sha1_stream_hash: streams byte messages through the valid/ready input,
// predicts each SHA-1 digest in-bench and checks every output word in order.
// Depends only on the RTL top level (sha1_stream_hash) and its package.
module tb_sha1_stream_hash;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 200;
	localparam int unsigned REPORT_MAX  = 10;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef struct packed {
		logic [31:0] digest;
		logic [2:0]  pos;
		logic        is_last;
	} digest_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [7:0]  message_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// predictor state
	logic [31:0] hash_words [5];
	logic [7:0]  block_bytes [64];
	int unsigned block_fill;
	logic [63:0] byte_count;

	digest_word_t digest_q [$];

	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned words_checked;
	int unsigned bytes_sent;
	int unsigned messages_sent;
	int unsigned items_sent;
	bit          gaps_on;
	bit          stalls_on;
	int unsigned stall_left;

	sha1_stream_hash uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.message_byte (message_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
		for (int r = 16; r < 80; r++)
			w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = hash_words[0];
		b = hash_words[1];
		c = hash_words[2];
		d = hash_words[3];
		e = hash_words[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = rol32(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = t;
		end
		hash_words[0] += a;
		hash_words[1] += b;
		hash_words[2] += c;
		hash_words[3] += d;
		hash_words[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] v);
		block_bytes[block_fill] = v;
		block_fill++;
		if (block_fill == 64) begin
			sha1_compress();
			block_fill = 0;
		end
	endfunction

	function automatic void clear_hash_state();
		for (int i = 0; i < 5; i++)
			hash_words[i] = H_INIT[i];
		block_fill = 0;
		byte_count = '0;
	endfunction

	// Update the prediction for one accepted word; a finish queues the five digest words.
	function automatic void predict_digest(input logic cmd, input logic [7:0] b);
		logic [63:0]  bit_len;
		digest_word_t dw;
		if (cmd == CMD_APPEND) begin
			byte_count++;
			absorb_byte(b);
		end else begin
			bit_len = byte_count << 3;
			absorb_byte(8'h80);
			while (block_fill != 56)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(bit_len[63 - 8*i -: 8]);
			for (int i = 0; i < 5; i++) begin
				dw.digest  = hash_words[i];
				dw.pos     = 3'(i);
				dw.is_last = (i == 4);
				digest_q = {digest_q, dw};
			end
			clear_hash_state();
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_digest(command, message_byte);
	end

	always @(posedge clk) begin
		digest_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected output word: digest=%08h index=%0d last=%0b",
						digest_word, word_index, last_word);
			end else begin
				exp_w = digest_q.pop_front();
				words_checked++;
				if (digest_word !== exp_w.digest || word_index !== exp_w.pos ||
						last_word !== exp_w.is_last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("digest word mismatch: expected %08h/%0d/%0b got %08h/%0d/%0b",
							exp_w.digest, exp_w.pos, exp_w.is_last,
							digest_word, word_index, last_word);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[sha1_stream_hash] ERROR");
			$finish;
		end
	end

	// Receiver: stall in random bursts while stalls are enabled.
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				out_ready  = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Drive one word at the falling edge and hold it until accepted.
	task automatic send_word(input logic cmd, input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid     = 1'b1;
		command      = cmd;
		message_byte = b;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
		items_sent++;
		if (cmd == CMD_APPEND)
			bytes_sent++;
		else
			messages_sent++;
	endtask

	task automatic send_random_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_word(CMD_APPEND, 8'($urandom_range(0, 255)));
		send_word(CMD_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_all_digests();
		while (digest_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_message();
		send_word(CMD_FINISH, 8'h00);
		// second finish must see the state returned to its initial values
		send_word(CMD_FINISH, 8'hFF);
	endtask

	task automatic test_short_vectors();
		send_word(CMD_APPEND, 8'h61);
		send_word(CMD_APPEND, 8'h62);
		send_word(CMD_APPEND, 8'h63);
		send_word(CMD_FINISH, 8'h00);
		send_word(CMD_APPEND, 8'h00);
		send_word(CMD_FINISH, 8'hA5);
		send_word(CMD_APPEND, 8'hFF);
		send_word(CMD_FINISH, 8'h5A);
		send_word(CMD_APPEND, 8'h55);
		send_word(CMD_APPEND, 8'hAA);
		send_word(CMD_FINISH, 8'hFF);
	endtask

	// Padding fits in one block at 55 bytes, needs a second at 56, a full extra at 64.
	task automatic test_pad_boundaries();
		send_random_message(55);
		send_random_message(56);
		send_random_message(64);
	endtask

	task automatic test_hold_until_drained();
		send_random_message(5);
		wait_all_digests();
		send_random_message(3);
		wait_all_digests();
	endtask

	task automatic test_random_messages();
		int unsigned len;
		while (items_sent < 270) begin
			gaps_on   = $urandom_range(0, 3) != 0;
			stalls_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(50, 70);
			else
				len = $urandom_range(0, 20);
			send_random_message(len);
			if ($urandom_range(0, 5) == 0)
				wait_all_digests();
		end
	endtask

	task automatic test_steady_stream();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		send_random_message(12);
		send_random_message(0);
		send_random_message(20);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		command        = CMD_APPEND;
		message_byte   = 8'h00;
		cycle_count    = 0;
		mismatch_count = 0;
		words_checked  = 0;
		bytes_sent     = 0;
		messages_sent  = 0;
		items_sent     = 0;
		gaps_on        = 1'b1;
		stalls_on      = 1'b1;
		clear_hash_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_message();
		test_short_vectors();
		test_pad_boundaries();
		test_hold_until_drained();
		test_random_messages();
		test_steady_stream();

		wait_all_digests();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d messages (%0d bytes), %0d digest words checked, %0d mismatches",
			messages_sent, bytes_sent, words_checked, mismatch_count);
		if (mismatch_count == 0 && digest_q.size() == 0) begin
			$display("[sha1_stream_hash] OK");
		end else begin
			$display("%0d digest words still outstanding", digest_q.size());
			$display("[sha1_stream_hash] ERROR");
		end
		$finish;
	end

endmodule
